// ===== rtl/core/swtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package swtc_pkg;

  localparam int POS_W       = 24;
  localparam int VAL_W       = 64;
  localparam int SLOT_W      = 5;
  localparam int STATUS_W    = 3;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 120;
  localparam int DEF_WINDOW  = 32;
  localparam int FIFO_DEPTH  = 2;

  typedef enum logic [MODE_W-1:0] {
    OP_MOVE = 2'd0,
    OP_ROW  = 2'd1,
    OP_DIAG = 2'd2,
    OP_FILL = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd4;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] column;
    logic [VAL_W-1:0] fill_value;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sliding_window_triangle_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata (low bit up)                  | tuser  | tlast
// in_     | in  | position, column, fill_value        | mode   | -
// out_    | out | slot, value, row_pos, col_pos, pad  | status | last
//
// row or diagonal query: for each result a read is issued and its data taken, in turn,
// set by the single read port of the value store
// move by d < WINDOW: d rows of WINDOW cell writes; larger jump or reset: a
// clearing pass over WINDOW*(WINDOW+1)/2 cells (528 at 32) in the back end
// fill: one store write if the cell lies in the window; a two-entry command queue lets the input side run ahead
// a busy or stalled back end fills the queue, then in_tready drops
module sliding_window_triangle_cache_unit #(
  parameter int WINDOW = swtc_pkg::DEF_WINDOW
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [swtc_pkg::IN_TDATA_W-1:0]   in_tdata,   // position, column, fill_value
  input  wire logic [swtc_pkg::MODE_W-1:0]       in_tuser,   // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [swtc_pkg::OUT_TDATA_W-1:0]       out_tdata,  // slot, value, row_pos, col_pos
  output logic [swtc_pkg::STATUS_W-1:0]          out_tuser,  // status
  output logic                                   out_tlast
);

  logic           push_valid;
  logic           push_ready;
  swtc_pkg::cmd_t push_cmd;
  logic           q_valid;
  logic           q_ready;
  swtc_pkg::cmd_t q_cmd;
  logic           ram_wr_en;
  logic           ram_rd_en;

  swtc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  swtc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  swtc_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .ram_wr_en  (ram_wr_en),
    .ram_rd_en  (ram_rd_en)
  );

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("store written and read in one cycle");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= swtc_pkg::ST_REJECT)
    else $error("status code out of range");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == swtc_pkg::ST_OUTSIDE |->
      out_tdata[swtc_pkg::VAL_W+4:5] == '0)
    else $error("outside result carries a value");

endmodule
`default_nettype wire

// ===== rtl/core/swtc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/swtc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtc_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [swtc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [swtc_pkg::MODE_W-1:0]        in_tuser,
  output logic                                    push_valid,
  input  wire logic                               push_ready,
  output swtc_pkg::cmd_t                          push_cmd
);

  logic           hold_v_r;
  swtc_pkg::cmd_t hold_r;

  assign in_tready  = !hold_v_r || push_ready;
  assign push_valid = hold_v_r;
  assign push_cmd   = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tready) begin
      hold_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      hold_r.op         <= swtc_pkg::op_t'(in_tuser);
      hold_r.position   <= in_tdata[swtc_pkg::POS_W-1:0];
      hold_r.column     <= in_tdata[2*swtc_pkg::POS_W-1:swtc_pkg::POS_W];
      hold_r.fill_value <= in_tdata[2*swtc_pkg::POS_W+swtc_pkg::VAL_W-1:2*swtc_pkg::POS_W];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/swtc_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtc_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire swtc_pkg::cmd_t wr_cmd,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output swtc_pkg::cmd_t      rd_cmd
);

  localparam int PW = $clog2(swtc_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(swtc_pkg::FIFO_DEPTH + 1);

  swtc_pkg::cmd_t  slots_r [swtc_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = cnt_r != CW'(swtc_pkg::FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = slots_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(swtc_pkg::FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(swtc_pkg::FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_wr) begin
      slots_r[wp_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/swtc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtc_back #(
  parameter int WINDOW = swtc_pkg::DEF_WINDOW
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_ready,
  input  wire swtc_pkg::cmd_t                      cmd,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [swtc_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [swtc_pkg::STATUS_W-1:0]            out_tuser,
  output logic                                     out_tlast,
  output logic                                     ram_wr_en,
  output logic                                     ram_rd_en
);

  localparam int NCELLS = (WINDOW * (WINDOW + 1)) / 2;
  localparam int AW     = $clog2(NCELLS);
  localparam int SW     = $clog2(WINDOW);
  localparam int PW     = swtc_pkg::POS_W;
  localparam int VW     = swtc_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_WIPE, S_IDLE, S_CLR, S_FILL, S_DONE, S_RD_ISSUE, S_RD_DATA
  } state_t;

  function automatic logic [SW-1:0] wrap_add(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SW+1)'(WINDOW)) begin
      s = s - (SW+1)'(WINDOW);
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_f(logic [SW-1:0] a, logic [SW-1:0] b);
    int r;
    int c;
    int n;
    r = (a > b) ? int'(a) : int'(b);
    c = (a > b) ? int'(b) : int'(a);
    n = c * WINDOW - (c * (c - 1)) / 2 + (r - c);
    return AW'(n);
  endfunction

  state_t           state_r;
  swtc_pkg::cmd_t   cmd_r;
  logic [PW-1:0]    ws_r;
  logic [SW-1:0]    ss_r;
  logic [SW-1:0]    k_r;
  logic [SW-1:0]    rows_r;
  logic [SW-1:0]    crow_r;
  logic [AW-1:0]    wipe_r;
  logic             wipe_move_r;

  logic                          out_valid_r;
  logic [swtc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [swtc_pkg::STATUS_W-1:0] out_user_r;
  logic                          out_last_r;

  logic [VW:0]      rd_data;
  logic [AW-1:0]    wr_addr;
  logic [VW:0]      wr_data;
  logic [AW-1:0]    rd_addr;

  logic             out_free;
  logic             out_load;
  logic [PW-1:0]    diff;
  logic             fwd;
  logic             big_jump;
  logic [SW-1:0]    d_small;
  logic             pos_in;
  logic             col_in;
  logic [PW-1:0]    row_off;
  logic [PW-1:0]    col_off;
  logic [SW-1:0]    lr;
  logic [SW-1:0]    lcf;
  logic [SW-1:0]    lc;
  logic [PW-1:0]    gk;
  logic             k_last;

  logic [2:0]       res_status;
  logic [4:0]       res_slot;
  logic [VW-1:0]    res_value;
  logic [PW-1:0]    res_row;
  logic [PW-1:0]    res_col;

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == S_DONE || state_r == S_RD_DATA) && out_free;
  assign fwd      = cmd.position > ws_r;
  assign diff     = fwd ? cmd.position - ws_r : ws_r - cmd.position;
  assign big_jump = diff >= PW'(WINDOW);
  assign d_small  = diff[SW-1:0];

  assign pos_in  = cmd_r.position >= ws_r &&
                   {1'b0, cmd_r.position} < {1'b0, ws_r} + (PW+1)'(WINDOW);
  assign col_in  = cmd_r.column >= ws_r &&
                   {1'b0, cmd_r.column} < {1'b0, ws_r} + (PW+1)'(WINDOW);
  assign row_off = cmd_r.position - ws_r;
  assign col_off = cmd_r.column - ws_r;
  assign lr      = wrap_add(row_off[SW-1:0], ss_r);
  assign lcf     = wrap_add(col_off[SW-1:0], ss_r);
  assign lc      = wrap_add(k_r, ss_r);
  assign gk      = ws_r + PW'(k_r);
  assign k_last  = k_r == SW'(WINDOW - 1);

  assign cmd_ready = state_r == S_IDLE;

  always_comb begin
    ram_wr_en = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    case (state_r)
      S_WIPE: begin
        ram_wr_en = 1'b1;
        wr_addr   = wipe_r;
      end
      S_CLR: begin
        ram_wr_en = 1'b1;
        wr_addr   = cell_f(crow_r, k_r);
      end
      S_FILL: begin
        ram_wr_en = pos_in && col_in;
        wr_addr   = cell_f(lr, lcf);
        wr_data   = {1'b1, cmd_r.fill_value};
      end
      default: begin
      end
    endcase
  end

  assign ram_rd_en = state_r == S_RD_ISSUE;
  assign rd_addr   = (cmd_r.op == swtc_pkg::OP_ROW) ? cell_f(lr, lc) : cell_f(lc, lc);

  swtc_ram #(
    .WIDTH (VW + 1),
    .DEPTH (NCELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    res_status = swtc_pkg::ST_DONE;
    res_slot   = '0;
    res_value  = '0;
    res_row    = cmd_r.position;
    res_col    = cmd_r.column;
    if (state_r == S_RD_DATA) begin
      res_slot = 5'(k_r);
      res_col  = gk;
      if (cmd_r.op == swtc_pkg::OP_DIAG) begin
        res_row = gk;
      end
      if (cmd_r.op == swtc_pkg::OP_ROW && !pos_in) begin
        res_status = swtc_pkg::ST_OUTSIDE;
      end else if (rd_data[VW]) begin
        res_status = swtc_pkg::ST_HIT;
        res_value  = rd_data[VW-1:0];
      end else begin
        res_status = swtc_pkg::ST_MISS;
      end
    end else if (cmd_r.op == swtc_pkg::OP_MOVE) begin
      res_slot = 5'(ss_r);
      res_row  = ws_r;
      res_col  = '0;
    end else if (pos_in && col_in) begin
      res_slot  = 5'(col_off);
      res_value = cmd_r.fill_value;
    end else begin
      res_status = swtc_pkg::ST_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      ws_r        <= '0;
      ss_r        <= '0;
      k_r         <= '0;
      rows_r      <= '0;
      crow_r      <= '0;
      wipe_r      <= '0;
      wipe_move_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_WIPE: begin
          if (wipe_r == AW'(NCELLS - 1)) begin
            wipe_r  <= '0;
            state_r <= wipe_move_r ? S_DONE : S_IDLE;
          end else begin
            wipe_r <= wipe_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            k_r   <= '0;
            case (cmd.op)
              swtc_pkg::OP_MOVE: begin
                ws_r <= cmd.position;
                if (big_jump) begin
                  ss_r        <= '0;
                  wipe_move_r <= 1'b1;
                  state_r     <= S_WIPE;
                end else begin
                  rows_r  <= d_small;
                  crow_r  <= fwd ? ss_r : wrap_add(ss_r, SW'(WINDOW) - d_small);
                  ss_r    <= fwd ? wrap_add(ss_r, d_small)
                                 : wrap_add(ss_r, SW'(WINDOW) - d_small);
                  state_r <= (d_small == '0) ? S_DONE : S_CLR;
                end
              end
              swtc_pkg::OP_FILL: state_r <= S_FILL;
              default:           state_r <= S_RD_ISSUE;
            endcase
          end
        end
        S_CLR: begin
          if (k_last) begin
            k_r    <= '0;
            crow_r <= wrap_add(crow_r, SW'(1));
            rows_r <= rows_r - 1'b1;
            if (rows_r == SW'(1)) begin
              state_r <= S_DONE;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FILL: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            wipe_move_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_RD_ISSUE: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          if (out_free) begin
            k_r     <= k_r + 1'b1;
            state_r <= k_last ? S_IDLE : S_RD_ISSUE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (out_load) begin
      out_user_r <= res_status;
      out_last_r <= (state_r == S_DONE) || k_last;
      out_data_r <= {3'b000, res_col, res_row, res_value, res_slot};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
